// ===== rtl/core/jtsq_pkg.sv =====
// Shared types, TAP tables and helper functions for the JTAG TAP master sequencer.
`timescale 1ns / 1ps
package jtsq_pkg;

    // Field widths
    localparam int STATE_W = 4;
    localparam int DATA_W  = 8;
    localparam int COUNT_W = 4;

    // Chain reset length and result limit per command
    localparam int RESET_CLOCKS = 32;
    localparam int MAX_RESULTS  = 32;
    localparam int IDX_W        = $clog2(MAX_RESULTS);
    localparam int RST_TOTAL    = (RESET_CLOCKS > MAX_RESULTS) ? MAX_RESULTS :
                                  ((RESET_CLOCKS < 1) ? 1 : RESET_CLOCKS);
    localparam logic [IDX_W-1:0] RST_LAST = IDX_W'(RST_TOTAL - 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_RESULTS - 1);

    // Largest shift length
    localparam logic [COUNT_W-1:0] MAX_SHIFT = COUNT_W'(DATA_W);

    // Test-Logic-Reset
    localparam logic [STATE_W-1:0] TAP_TLR = '0;

    // Command opcodes
    typedef enum logic [1:0] {
        OP_RESET = 2'd0,
        OP_GOTO  = 2'd1,
        OP_SHIFT = 2'd2
    } op_t;

    // Back-end sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } seq_state_t;

    // Classified command as it travels through the queue
    typedef struct packed {
        op_t                op;
        logic [STATE_W-1:0] target;
        logic [DATA_W-1:0]  data;
        logic [COUNT_W-1:0] count;
        logic               exit_last;
        logic [DATA_W-1:0]  tdo;
    } cmd_t;

    // High nibble: successor for TMS=1, low nibble: successor for TMS=0
    localparam logic [7:0] TAP_NEXT [16] = '{
        8'h01, 8'h21, 8'h93, 8'h54, 8'h54, 8'h86, 8'h76, 8'h84,
        8'h21, 8'h0A, 8'hCB, 8'hCB, 8'hFD, 8'hED, 8'hFB, 8'h21
    };

    // Bit w of entry s: TMS to drive in state s to move toward state w
    localparam logic [15:0] TAP_ROUTE [16] = '{
        16'h0001, 16'hFFFD, 16'hFE03, 16'hFFE7,
        16'hFFEF, 16'hFF0F, 16'hFFBF, 16'hFF0F,
        16'hFEFD, 16'h01FF, 16'hF3FF, 16'hF7FF,
        16'h87FF, 16'hDFFF, 16'h87FF, 16'hFEFD
    };

    function automatic logic [STATE_W-1:0] tap_succ(input logic [STATE_W-1:0] s,
                                                     input logic tms);
        logic [7:0] entry;
        entry = TAP_NEXT[s];
        return tms ? entry[7:4] : entry[3:0];
    endfunction

    function automatic logic route_tms(input logic [STATE_W-1:0] s,
                                       input logic [STATE_W-1:0] target);
        logic [15:0] entry;
        entry = TAP_ROUTE[s];
        return entry[target];
    endfunction

endpackage

// ===== rtl/core/jtag_tap_master_sequencer.sv =====
// Top level of the JTAG TAP master sequencer: front end, command queue and back end.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+----------------------------------------------
//  in      | input     | in_valid / in_stall | opcode, target_state, shift_data, bit_count,
//          |           |                     | exit_on_last, tdo_levels
//  out     | output    | out_valid/out_stall | tdi_level, tms_level, captured_byte,
//          |           |                     | state_after, last_clock
//
// A command yields one result per cycle while the output is not stalled: 32 for reset,
// up to 32 for goto, 1 to 8 for shift. The back end loads each command from the queue
// in its idle state before it runs it, and a goto that is already at its target gives
// no result.
// Two commands can wait in the queue while the back end runs; in_stall rises when it is full.
// Commands that give no result (unused opcode, zero-length shift) are accepted and dropped.
// Reset puts the tracked TAP state in Test-Logic-Reset and empties queue and output register.
`timescale 1ns / 1ps
module jtag_tap_master_sequencer
    import jtsq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic [STATE_W-1:0] target_state,
    input  logic [DATA_W-1:0]  shift_data,
    input  logic [COUNT_W-1:0] bit_count,
    input  logic               exit_on_last,
    input  logic [DATA_W-1:0]  tdo_levels,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               tdi_level,
    output logic               tms_level,
    output logic [DATA_W-1:0]  captured_byte,
    output logic [STATE_W-1:0] state_after,
    output logic               last_clock
);

    logic q_full;
    logic q_not_empty;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t head_cmd;

    jtsq_front u_front (
        .in_valid     (in_valid),
        .q_full       (q_full),
        .opcode       (opcode),
        .target_state (target_state),
        .shift_data   (shift_data),
        .bit_count    (bit_count),
        .exit_on_last (exit_on_last),
        .tdo_levels   (tdo_levels),
        .in_stall     (in_stall),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    jtsq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    jtsq_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_cmd         (head_cmd),
        .q_pop         (pop),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .tdi_level     (tdi_level),
        .tms_level     (tms_level),
        .captured_byte (captured_byte),
        .state_after   (state_after),
        .last_clock    (last_clock)
    );

endmodule

// ===== rtl/core/jtsq_front.sv =====
// Front end: accepts input transactions, classifies them and clamps the shift length.
`timescale 1ns / 1ps
module jtsq_front
    import jtsq_pkg::*;
(
    input  logic               in_valid,
    input  logic               q_full,
    input  logic [1:0]         opcode,
    input  logic [STATE_W-1:0] target_state,
    input  logic [DATA_W-1:0]  shift_data,
    input  logic [COUNT_W-1:0] bit_count,
    input  logic               exit_on_last,
    input  logic [DATA_W-1:0]  tdo_levels,
    output logic               in_stall,
    output logic               push,
    output cmd_t               push_cmd
);

    logic               accept;
    logic [COUNT_W-1:0] count_clamped;
    logic               keep;

    // Hold off new transactions while the queue has no room
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Clamp shift length to one byte
    assign count_clamped = (bit_count > MAX_SHIFT) ? MAX_SHIFT : bit_count;

    // Drop commands that can never produce a result
    always_comb
    begin
        keep = 1'b0;
        case (opcode)
            OP_RESET: keep = 1'b1;
            OP_GOTO:  keep = 1'b1;
            OP_SHIFT: keep = (count_clamped != '0);
            default:  keep = 1'b0;
        endcase
    end

    // Build the queued command
    always_comb
    begin
        push_cmd.op        = op_t'(opcode);
        push_cmd.target    = target_state;
        push_cmd.data      = shift_data;
        push_cmd.count     = count_clamped;
        push_cmd.exit_last = exit_on_last;
        push_cmd.tdo       = tdo_levels;
    end

    assign push = accept && keep;

endmodule

// ===== rtl/core/jtsq_queue.sv =====
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps
module jtsq_queue
    import jtsq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output cmd_t head_cmd
);

    cmd_t       mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       do_push;
    logic       do_pop;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_cmd  = mem[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the command payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/jtsq_back.sv =====
// Back end: tracks the TAP state and emits one TCK clock result per cycle while the output is not stalled.
`timescale 1ns / 1ps
module jtsq_back
    import jtsq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_not_empty,
    input  cmd_t               q_cmd,
    output logic               q_pop,
    input  logic               out_stall,
    output logic               out_valid,
    output logic               tdi_level,
    output logic               tms_level,
    output logic [DATA_W-1:0]  captured_byte,
    output logic [STATE_W-1:0] state_after,
    output logic               last_clock
);

    seq_state_t         state_reg;
    seq_state_t         state_next;
    logic [STATE_W-1:0] tap_reg;
    logic [STATE_W-1:0] tap_next;
    cmd_t               cmd_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               tdi_reg;
    logic               tms_reg;
    logic [DATA_W-1:0]  cap_reg;
    logic [STATE_W-1:0] st_reg;
    logic               last_reg;

    logic               can_emit;
    logic               emit;
    logic               finish;
    logic               e_tdi;
    logic               e_tms;
    logic [DATA_W-1:0]  e_cap;
    logic [STATE_W-1:0] e_st;
    logic               e_last;
    logic [2:0]         bit_idx;

    assign can_emit = !out_valid_reg || !out_stall;
    assign q_pop    = (state_reg == ST_IDLE) && q_not_empty;
    assign bit_idx  = idx_reg[2:0];

    // Next state of the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (q_not_empty) state_next = ST_RUN;
            ST_RUN:  if (finish) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Work out the clock to emit for the active command
    always_comb
    begin
        emit     = 1'b0;
        finish   = 1'b0;
        e_tdi    = 1'b1;
        e_tms    = 1'b1;
        e_cap    = '0;
        e_st     = tap_reg;
        e_last   = 1'b0;
        tap_next = tap_reg;
        if (state_reg == ST_RUN)
        begin
            case (cmd_reg.op)
                OP_RESET:
                begin
                    e_last = (idx_reg == RST_LAST);
                    e_st   = e_last ? TAP_TLR : tap_succ(tap_reg, 1'b1);
                    if (can_emit)
                    begin
                        emit     = 1'b1;
                        tap_next = e_st;
                        finish   = e_last;
                    end
                end
                OP_GOTO:
                begin
                    e_tms  = route_tms(tap_reg, cmd_reg.target);
                    e_st   = tap_succ(tap_reg, e_tms);
                    e_last = (e_st == cmd_reg.target);
                    if (tap_reg == cmd_reg.target)
                    begin
                        finish = 1'b1;
                    end
                    else if (can_emit)
                    begin
                        emit     = 1'b1;
                        tap_next = e_st;
                        finish   = e_last || (idx_reg == IDX_LAST);
                    end
                end
                OP_SHIFT:
                begin
                    e_last = ({1'b0, bit_idx} == (cmd_reg.count - COUNT_W'(1)));
                    e_tms  = cmd_reg.exit_last && e_last;
                    e_tdi  = cmd_reg.data[bit_idx];
                    e_st   = e_tms ? tap_succ(tap_reg, 1'b1) : tap_reg;
                    // Keep returned TDO bits up to the current clock
                    for (int j = 0; j < DATA_W; j++)
                    begin
                        e_cap[j] = cmd_reg.tdo[j] && (3'(j) <= bit_idx);
                    end
                    if (can_emit)
                    begin
                        emit = 1'b1;
                        if (e_last)
                        begin
                            tap_next = e_st;
                            finish   = 1'b1;
                        end
                    end
                end
                default: finish = 1'b1;
            endcase
        end
    end

    // Advance the clock index, restart it on each new command
    always_comb
    begin
        idx_next = idx_reg;
        if (q_pop)
        begin
            idx_next = '0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    // Hold the result until it is taken
    assign out_valid_next = emit ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_reg       <= TAP_TLR;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_reg       <= tap_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load command and result payloads
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (emit)
        begin
            tdi_reg  <= e_tdi;
            tms_reg  <= e_tms;
            cap_reg  <= e_cap;
            st_reg   <= e_st;
            last_reg <= e_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign tdi_level     = tdi_reg;
    assign tms_level     = tms_reg;
    assign captured_byte = cap_reg;
    assign state_after   = st_reg;
    assign last_clock    = last_reg;

endmodule

// ===== rtl/core/jtsq_checker.sv =====
// Port-level checker for the JTAG TAP master sequencer, bound to the top level.
`timescale 1ns / 1ps
module jtsq_checker
    import jtsq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic               tdi_level,
    input logic               tms_level,
    input logic [DATA_W-1:0]  captured_byte,
    input logic [STATE_W-1:0] state_after,
    input logic               last_clock
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(tdi_level) && $stable(tms_level) &&
            $stable(captured_byte) && $stable(state_after) && $stable(last_clock))
        else $error("result payload changed while stalled");

    // TMS high before the final clock only comes from reset or goto walks
    a_tms_walk: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tms_level && !last_clock |-> tdi_level && (captured_byte == '0))
        else $error("TMS high inside a shift");

    // No result right after reset is released
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result offered out of reset");

endmodule

bind jtag_tap_master_sequencer jtsq_checker u_jtsq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .tdi_level     (tdi_level),
    .tms_level     (tms_level),
    .captured_byte (captured_byte),
    .state_after   (state_after),
    .last_clock    (last_clock)
);

// ===== dv/jtag_tap_master_sequencer_test.sv =====
// Self-checking testbench for the JTAG TAP master sequencer with a TCK clock scoreboard.
`timescale 1ns / 1ps
module jtag_tap_master_sequencer_test
    import jtsq_pkg::*;
;

    localparam int CLK_PERIOD       = 10;
    localparam int CHAIN_RST_CLOCKS = 32;
    localparam int TCK_BUF_DEPTH    = 32;
    localparam int RANDOM_CMDS      = 187;
    localparam int CALM_FROM        = 160;
    localparam int DRAIN_AT         = 100;
    localparam int SETTLE_CYCLES    = 40;
    localparam int QUIET_LIMIT      = 1000;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    // TAP controller states in next-state table encoding
    typedef enum logic [3:0] {
        S_TLR, S_RTI, S_SEL_DR, S_CAP_DR, S_SHIFT_DR, S_EXIT1_DR, S_PAUSE_DR, S_EXIT2_DR,
        S_UPD_DR, S_SEL_IR, S_CAP_IR, S_SHIFT_IR, S_EXIT1_IR, S_PAUSE_IR, S_EXIT2_IR, S_UPD_IR
    } tap_state_t;

    // Expand commands into expected TCK transactions and check each result against them
    class tap_scoreboard;
        typedef struct packed {
            logic       tdi;
            logic       tms;
            logic [7:0] cap;
            logic [3:0] st;
            logic       last;
        } tck_t;

        tck_t       pending_tcks[$];
        logic [3:0] tracked_state;
        bit   [7:0] succ_tab [16];
        bit  [15:0] route_tab [16];
        int         errors;
        int         n_reset, n_goto, n_shift, n_dropped, n_checked;

        function new();
            succ_tab  = '{8'h01, 8'h21, 8'h93, 8'h54, 8'h54, 8'h86, 8'h76, 8'h84,
                          8'h21, 8'h0A, 8'hCB, 8'hCB, 8'hFD, 8'hED, 8'hFB, 8'h21};
            route_tab = '{16'h0001, 16'hFFFD, 16'hFE03, 16'hFFE7,
                          16'hFFEF, 16'hFF0F, 16'hFFBF, 16'hFF0F,
                          16'hFEFD, 16'h01FF, 16'hF3FF, 16'hF7FF,
                          16'h87FF, 16'hDFFF, 16'h87FF, 16'hFEFD};
            tracked_state = S_TLR;
            errors = 0;
            n_reset = 0; n_goto = 0; n_shift = 0; n_dropped = 0; n_checked = 0;
        endfunction

        function logic [3:0] step_state(input logic [3:0] s, input logic tms);
            return tms ? succ_tab[s][7:4] : succ_tab[s][3:0];
        endfunction

        function void push_tck(input logic tdi, input logic tms, input logic [7:0] cap,
                               input logic [3:0] st, input logic last);
            tck_t t;
            t.tdi = tdi; t.tms = tms; t.cap = cap; t.st = st; t.last = last;
            pending_tcks.push_back(t);
        endfunction

        function void expand_command(input logic [1:0] op, input logic [3:0] target,
                                     input logic [7:0] data, input logic [3:0] count,
                                     input logic ex, input logic [7:0] tdo);
            int         total;
            int         n;
            logic [3:0] s;
            logic [7:0] cap;
            logic       tms;
            logic       last;
            int         len;
            case (op)
                OP_RESET:
                begin
                    n_reset++;
                    total = (CHAIN_RST_CLOCKS > TCK_BUF_DEPTH) ? TCK_BUF_DEPTH :
                            ((CHAIN_RST_CLOCKS < 1) ? 1 : CHAIN_RST_CLOCKS);
                    s = tracked_state;
                    for (n = 0; n < total; n++)
                    begin
                        s = step_state(s, 1'b1);
                        if (n == total - 1)
                            s = S_TLR;
                        push_tck(1'b1, 1'b1, 8'h00, s, n == total - 1);
                    end
                    tracked_state = S_TLR;
                end
                OP_GOTO:
                begin
                    n_goto++;
                    n = 0;
                    while (tracked_state != target && n < TCK_BUF_DEPTH)
                    begin
                        tms = route_tab[tracked_state][target];
                        tracked_state = step_state(tracked_state, tms);
                        push_tck(1'b1, tms, 8'h00, tracked_state, tracked_state == target);
                        n++;
                    end
                end
                OP_SHIFT:
                begin
                    len = (count > 4'd8) ? 8 : int'(count);
                    if (len == 0)
                        n_dropped++;
                    else
                        n_shift++;
                    cap = 8'h00;
                    for (n = 0; n < len; n++)
                    begin
                        last = (n == len - 1);
                        tms = ex & last;
                        cap[n] = tdo[n];
                        s = tms ? step_state(tracked_state, 1'b1) : tracked_state;
                        push_tck(data[n], tms, cap, s, last);
                    end
                    if (len > 0 && ex)
                        tracked_state = step_state(tracked_state, 1'b1);
                end
                default:
                    n_dropped++;
            endcase
        endfunction

        function void check_tck(input logic tdi, input logic tms, input logic [7:0] cap,
                                input logic [3:0] st, input logic last);
            tck_t exp_tck;
            if (pending_tcks.size() == 0)
            begin
                $error("unexpected TCK transaction: tdi=%0d tms=%0d cap=%02h st=%0d last=%0d",
                       tdi, tms, cap, st, last);
                errors++;
                return;
            end
            exp_tck = pending_tcks.pop_front();
            n_checked++;
            if (tdi !== exp_tck.tdi)
            begin
                $error("tdi_level: expected %0d, got %0d", exp_tck.tdi, tdi);
                errors++;
            end
            if (tms !== exp_tck.tms)
            begin
                $error("tms_level: expected %0d, got %0d", exp_tck.tms, tms);
                errors++;
            end
            if (cap !== exp_tck.cap)
            begin
                $error("captured_byte: expected %02h, got %02h", exp_tck.cap, cap);
                errors++;
            end
            if (st !== exp_tck.st)
            begin
                $error("state_after: expected %0d, got %0d", exp_tck.st, st);
                errors++;
            end
            if (last !== exp_tck.last)
            begin
                $error("last_clock: expected %0d, got %0d", exp_tck.last, last);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         opcode = '0;
    logic [STATE_W-1:0] target_state = '0;
    logic [DATA_W-1:0]  shift_data = '0;
    logic [COUNT_W-1:0] bit_count = '0;
    logic               exit_on_last = 1'b0;
    logic [DATA_W-1:0]  tdo_levels = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               tdi_level;
    logic               tms_level;
    logic [DATA_W-1:0]  captured_byte;
    logic [STATE_W-1:0] state_after;
    logic               last_clock;

    tap_scoreboard sb = new();
    bit            calm = 1'b0;
    int            quiet_cycles = 0;

    jtag_tap_master_sequencer dut (.*);

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Record accepted commands and check accepted TCK results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_tck(tdi_level, tms_level, captured_byte, state_after, last_clock);
            if (in_valid && !in_stall)
                sb.expand_command(opcode, target_state, shift_data, bit_count,
                                  exit_on_last, tdo_levels);
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $error("no transaction for %0d cycles, %0d TCK results outstanding",
                       QUIET_LIMIT, sb.pending_tcks.size());
                $display("jtag_tap_master_sequencer_test failed");
                $finish;
            end
        end
    end

    // Stall the result side in random bursts, release it in the calm tail
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (calm)
                out_stall <= 1'b0;
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 12))
                    @(negedge clk);
                if (!calm && $urandom_range(0, 1) == 1)
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(1, 14) - 1)
                        @(negedge clk);
                end
            end
        end
    end

    // Present one command and hold it until accepted; entered and left at a falling edge
    task automatic send_cmd(input logic [1:0] op, input logic [3:0] tgt,
                            input logic [7:0] data, input logic [3:0] cnt,
                            input logic ex, input logic [7:0] tdo);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        target_state <= tgt;
        shift_data   <= data;
        bit_count    <= cnt;
        exit_on_last <= ex;
        tdo_levels   <= tdo;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Drop valid and hold off until every expected TCK result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending_tcks.size() != 0);
    endtask

    initial
    begin
        int         sent;
        int         pick;
        logic [1:0] op;
        logic [3:0] tgt;
        logic [7:0] data;
        logic [3:0] cnt;
        logic       ex;
        logic [7:0] tdo;

        repeat (5)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: chain reset, both shift paths, routing corners, dropped commands
        send_cmd(OP_RESET,  S_UPD_IR,   8'hFF, 4'd8,  1'b1, 8'hFF);
        send_cmd(OP_GOTO,   S_SHIFT_DR, 8'h00, 4'd0,  1'b0, 8'h00);
        send_cmd(OP_SHIFT,  S_TLR,      8'hFF, 4'd8,  1'b0, 8'h00);
        send_cmd(OP_SHIFT,  S_TLR,      8'h00, 4'd8,  1'b1, 8'hFF);
        send_cmd(OP_GOTO,   S_UPD_IR,   8'h00, 4'd0,  1'b0, 8'h00);
        send_cmd(OP_GOTO,   S_UPD_IR,   8'hFF, 4'd15, 1'b1, 8'hFF);
        send_cmd(OP_GOTO,   S_SHIFT_IR, 8'h00, 4'd0,  1'b0, 8'h00);
        send_cmd(OP_SHIFT,  S_TLR,      8'hC3, 4'd0,  1'b1, 8'h3C);
        send_cmd(OP_SHIFT,  S_TLR,      8'hA5, 4'd15, 1'b1, 8'h5A);
        send_cmd(OP_UNUSED, S_UPD_IR,   8'hFF, 4'd8,  1'b1, 8'hFF);
        send_cmd(OP_GOTO,   S_RTI,      8'h00, 4'd0,  1'b0, 8'h00);
        send_cmd(OP_SHIFT,  S_TLR,      8'h05, 4'd3,  1'b1, 8'h06);
        send_cmd(OP_GOTO,   S_PAUSE_DR, 8'h00, 4'd0,  1'b0, 8'h00);
        send_cmd(OP_SHIFT,  S_TLR,      8'h96, 4'd9,  1'b0, 8'h69);
        send_cmd(OP_GOTO,   S_EXIT2_IR, 8'h00, 4'd0,  1'b0, 8'h00);
        send_cmd(OP_GOTO,   S_UPD_DR,   8'h00, 4'd0,  1'b0, 8'h00);
        send_cmd(OP_GOTO,   S_SEL_IR,   8'h00, 4'd0,  1'b0, 8'h00);
        send_cmd(OP_GOTO,   S_TLR,      8'h00, 4'd0,  1'b0, 8'h00);
        send_cmd(OP_GOTO,   S_TLR,      8'h00, 4'd0,  1'b0, 8'h00);
        send_cmd(OP_RESET,  S_TLR,      8'h00, 4'd0,  1'b0, 8'h00);
        send_cmd(OP_SHIFT,  S_TLR,      8'h01, 4'd1,  1'b0, 8'h01);
        send_cmd(OP_GOTO,   S_CAP_IR,   8'h00, 4'd0,  1'b0, 8'h00);
        send_cmd(OP_SHIFT,  S_TLR,      8'h7E, 4'd1,  1'b1, 8'h80);
        drain_results();

        // Random: mostly routes into shift states followed by shifts, plus noise
        sent = 0;
        while (sent < RANDOM_CMDS)
        begin
            calm = (sent >= CALM_FROM);
            if (sent == DRAIN_AT)
                drain_results();
            pick = $urandom_range(0, 99);
            tgt  = 4'($urandom_range(0, 15));
            data = 8'($urandom);
            cnt  = 4'($urandom_range(0, 15));
            ex   = 1'($urandom_range(0, 1));
            tdo  = 8'($urandom);
            if (pick < 35)
            begin
                op = OP_GOTO;
                if ($urandom_range(0, 2) != 0)
                    tgt = ($urandom_range(0, 1) == 1) ? S_SHIFT_DR : S_SHIFT_IR;
            end
            else if (pick < 80)
            begin
                op = OP_SHIFT;
                cnt = 4'($urandom_range(1, 8));
            end
            else if (pick < 86)
                op = OP_RESET;
            else if (pick < 93)
            begin
                op = OP_SHIFT;
                cnt = ($urandom_range(0, 1) == 1) ? 4'd0 : 4'($urandom_range(9, 15));
            end
            else
                op = OP_UNUSED;
            send_cmd(op, tgt, data, cnt, ex, tdo);
            sent++;
        end
        in_valid <= 1'b0;

        // Wait out outstanding results, then let the back end settle
        while (sb.pending_tcks.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);

        $display("Ran %0d resets, %0d gotos, %0d shifts and %0d dropped commands;",
                 sb.n_reset, sb.n_goto, sb.n_shift, sb.n_dropped);
        $display("checked %0d TCK clocks with %0d mismatches.", sb.n_checked, sb.errors);
        if (sb.errors == 0 && sb.pending_tcks.size() == 0)
            $display("jtag_tap_master_sequencer_test passed");
        else
            $display("jtag_tap_master_sequencer_test failed");
        $finish;
    end

endmodule
